// ----- rtl/rgbnv_pkg.sv -----
// Shared types and constants for the RGB to NV12 converter.
// No dependencies; imported by rgbnv_fifo, the top level and the testbench.
package rgbnv_pkg;

  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned LOFF_W     = 22;
  localparam int unsigned COFF_W     = 23;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } pair_sum_t;

  typedef struct packed {
    logic [7:0]        luma;
    logic [LOFF_W-1:0] luma_offset;
    logic              chroma_valid;
    logic [7:0]        blue_diff;
    logic [7:0]        red_diff;
    logic [COFF_W-1:0] chroma_offset;
    logic              frame_end;
  } result_t;

endpackage

// ----- rtl/rgbnv_fifo.sv -----
// Result queue between the conversion pipeline and the output channel.
// Depends on rgbnv_pkg (result_t, FIFO_DEPTH).
module rgbnv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  rgbnv_pkg::result_t wdata_i,
  input  logic               rd_i,
  output rgbnv_pkg::result_t rdata_o,
  output logic               valid_o
);
  import rgbnv_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  result_t        mem_q [FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PW:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);

endmodule

// ----- rtl/rgb_to_nv12_bt601_converter_top.sv -----
// RGB to NV12 (BT.601 limited range) converter, top level.
// Depends on rgbnv_pkg and rgbnv_fifo.
//
// Usage:
//  - Input channel: one RGB pixel per beat (red_i/green_i/blue_i), raster
//    order, accepted when in_valid_i is high and in_stall_o is low.
//  - Output channel: one result beat per pixel: luma and its offset, plus
//    Cb/Cr and the chroma offset at each odd column of an odd row.
//  - Config channel: cfg_index_i selects frame width or height; a write
//    completes when cfg_valid_i and cfg_ready_o are high. Write only idle.
//  - Path: 3 stages; a pixel is registered in stage 1, then stage 2, then
//    queued. Throughput: one pixel per cycle while in_stall_o is low; every
//    pixel reads the line store, and odd columns of even rows also write it.
//  - Stall: results queue in a 4-entry buffer; in_stall_o rises once four
//    beats are accepted but not yet delivered, so no result is dropped.
//  - Reset: position counters clear, size returns to 640 x 480, queue
//    empties. The line store holds no reset state.
module rgb_to_nv12_bt601_converter_top #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     luma_o,
  output logic [rgbnv_pkg::LOFF_W-1:0]   luma_offset_o,
  output logic                           chroma_valid_o,
  output logic [7:0]                     blue_diff_o,
  output logic [7:0]                     red_diff_o,
  output logic [rgbnv_pkg::COFF_W-1:0]   chroma_offset_o,
  output logic                           frame_end_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  rgbnv_pkg::cfg_reg_e            cfg_index_i,
  input  logic [rgbnv_pkg::SIZE_W-1:0]   cfg_data_i
);
  import rgbnv_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned LD    = MAX_WIDTH / 2;
  localparam int unsigned LW    = $clog2(LD);
  localparam int unsigned LO_W  = RW + SIZE_W;
  localparam int unsigned CO_W  = 2 * SIZE_W + 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH) + 1;

  localparam logic [15:0] KY_R = 16'd66;
  localparam logic [15:0] KY_G = 16'd129;
  localparam logic [15:0] KY_B = 16'd25;
  localparam logic [15:0] K_RND16 = 16'd128;
  localparam logic [7:0]  KY_OFS = 8'd16;
  localparam logic signed [17:0] KC_38  = 18'sd38;
  localparam logic signed [17:0] KC_74  = 18'sd74;
  localparam logic signed [17:0] KC_112 = 18'sd112;
  localparam logic signed [17:0] KC_94  = 18'sd94;
  localparam logic signed [17:0] KC_18  = 18'sd18;
  localparam logic signed [17:0] KC_RND = 18'sd128;
  localparam logic signed [9:0]  KC_OFS = 10'sd128;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned maxv);
    logic [SIZE_W:0] m;
    logic [SIZE_W:0] t;
    m = (SIZE_W+1)'(maxv & ~32'd1);
    t = {1'b0, v & ~{{(SIZE_W-1){1'b0}}, 1'b1}};
    if (t < (SIZE_W+1)'(2)) t = (SIZE_W+1)'(2);
    if (t > m) t = m;
    return SIZE_W'(t);
  endfunction

  function automatic logic [7:0] clamp_u8(input logic signed [9:0] x);
    if (x < 10'sd0) return 8'd0;
    else if (x > 10'sd255) return 8'd255;
    else return x[7:0];
  endfunction

  localparam logic [SIZE_W-1:0] W_RST = eff_size(SIZE_W'(640), MAX_WIDTH);
  localparam logic [SIZE_W-1:0] H_RST = eff_size(SIZE_W'(480), MAX_HEIGHT);

  // Configuration (stored as effective even, saturated sizes)
  logic [SIZE_W-1:0] w_q, h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= W_RST;
      h_q <= H_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  w_q <= eff_size(cfg_data_i, MAX_WIDTH);
        CFG_FRAME_HEIGHT: h_q <= eff_size(cfg_data_i, MAX_HEIGHT);
        default:          w_q <= w_q;
      endcase
    end
  end

  // Stage 0: position, pair sums, line store access
  logic              acc;
  logic [CNT_W-1:0]  cnt_q;
  logic [CW-1:0]     col_q, col_e;
  logic [RW-1:0]     row_q, row_e;
  logic              eol, eof_row;
  logic [LW-1:0]     idx;
  logic [23:0]       left_q;
  pair_sum_t         cur_sum;
  pair_sum_t         line_mem [LD];
  pair_sum_t         rd_q;

  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    col_e   = (SIZE_W'(col_q) >= w_q) ? '0 : col_q;
    row_e   = (SIZE_W'(row_q) >= h_q) ? '0 : row_q;
    eol     = (SIZE_W'(col_e) + SIZE_W'(1)) == w_q;
    eof_row = (SIZE_W'(row_e) + SIZE_W'(1)) == h_q;
    idx     = LW'(col_e >> 1);
    cur_sum.r = 9'(left_q[23:16]) + 9'(red_i);
    cur_sum.g = 9'(left_q[15:8])  + 9'(green_i);
    cur_sum.b = 9'(left_q[7:0])   + 9'(blue_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (acc) begin
      if (!col_e[0]) left_q <= {red_i, green_i, blue_i};
      if (eol) begin
        col_q <= '0;
        row_q <= eof_row ? '0 : row_e + 1'b1;
      end else begin
        col_q <= col_e + 1'b1;
        row_q <= row_e;
      end
    end
  end

  // Odd columns of even rows write pair sums; the next odd row reads them back
  always_ff @(posedge clk_i) begin
    if (acc && col_e[0] && !row_e[0]) line_mem[idx] <= cur_sum;
    if (acc) rd_q <= line_mem[idx];
  end

  // Stage 1 registers
  logic          v1_q;
  logic [7:0]    r1_q, g1_q, b1_q;
  pair_sum_t     sum1_q;
  logic [CW-1:0] col1_q;
  logic [RW-1:0] row1_q;
  logic          ch1_q, fe1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= acc;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      r1_q   <= red_i;
      g1_q   <= green_i;
      b1_q   <= blue_i;
      sum1_q <= cur_sum;
      col1_q <= col_e;
      row1_q <= row_e;
      ch1_q  <= col_e[0] && row_e[0];
      fe1_q  <= eol && eof_row;
    end
  end

  // Stage 1 logic: luma, block averages, offsets
  logic [15:0]      y_sum;
  logic [9:0]       fr, fg, fb;
  logic [LO_W-1:0]  lo_full;
  logic [SIZE_W:0]  h_plus;
  logic [CO_W-1:0]  co_full;

  always_comb begin
    y_sum   = KY_R * 16'(r1_q) + KY_G * 16'(g1_q) + KY_B * 16'(b1_q) + K_RND16;
    fr      = 10'(sum1_q.r) + 10'(rd_q.r) + 10'd2;
    fg      = 10'(sum1_q.g) + 10'(rd_q.g) + 10'd2;
    fb      = 10'(sum1_q.b) + 10'(rd_q.b) + 10'd2;
    lo_full = LO_W'(row1_q) * LO_W'(w_q) + LO_W'(col1_q);
    h_plus  = (SIZE_W+1)'(h_q) + (SIZE_W+1)'(row1_q >> 1);
    co_full = CO_W'(w_q) * CO_W'(h_plus) + CO_W'({col1_q[CW-1:1], 1'b0});
  end

  // Stage 2 registers
  logic              v2_q;
  logic [7:0]        y2_q, ar2_q, ag2_q, ab2_q;
  logic [LOFF_W-1:0] lo2_q;
  logic [COFF_W-1:0] co2_q;
  logic              ch2_q, fe2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      y2_q  <= y_sum[15:8] + KY_OFS;
      ar2_q <= fr[9:2];
      ag2_q <= fg[9:2];
      ab2_q <= fb[9:2];
      lo2_q <= LOFF_W'(lo_full);
      co2_q <= COFF_W'(co_full);
      ch2_q <= ch1_q;
      fe2_q <= fe1_q;
    end
  end

  // Stage 2 logic: chroma
  logic signed [17:0] sar, sag, sab, cb_t, cr_t;
  result_t            res;

  always_comb begin
    sar  = $signed({10'd0, ar2_q});
    sag  = $signed({10'd0, ag2_q});
    sab  = $signed({10'd0, ab2_q});
    cb_t = KC_112 * sab - KC_38 * sar - KC_74 * sag + KC_RND;
    cr_t = KC_112 * sar - KC_94 * sag - KC_18 * sab + KC_RND;
    res.luma          = y2_q;
    res.luma_offset   = lo2_q;
    res.chroma_valid  = ch2_q;
    res.blue_diff     = ch2_q ? clamp_u8($signed(cb_t[17:8]) + KC_OFS) : 8'd0;
    res.red_diff      = ch2_q ? clamp_u8($signed(cr_t[17:8]) + KC_OFS) : 8'd0;
    res.chroma_offset = ch2_q ? co2_q : '0;
    res.frame_end     = fe2_q;
  end

  // Result queue and credit count
  result_t out_res;
  logic    pop;

  assign pop = out_valid_o && !out_stall_i;

  rgbnv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (v2_q),
    .wdata_i (res),
    .rd_i    (pop),
    .rdata_o (out_res),
    .valid_o (out_valid_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case ({acc, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign in_stall_o = (cnt_q == CNT_W'(FIFO_DEPTH));

  assign luma_o          = out_res.luma;
  assign luma_offset_o   = out_res.luma_offset;
  assign chroma_valid_o  = out_res.chroma_valid;
  assign blue_diff_o     = out_res.blue_diff;
  assign red_diff_o      = out_res.red_diff;
  assign chroma_offset_o = out_res.chroma_offset;
  assign frame_end_o     = out_res.frame_end;

  // Checks
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("outstanding beat count exceeds queue depth");

  a_out_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0))
    else $error("output beat without an accepted pixel");

  a_no_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !chroma_valid_o) |->
      (blue_diff_o == 8'd0 && red_diff_o == 8'd0 && chroma_offset_o == '0))
    else $error("chroma fields set on a luma-only beat");

  a_counters_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !eol) |=> (col_q == $past(col_e) + 1'b1))
    else $error("column counter did not advance");

endmodule

// ----- sim/rgb_to_nv12_bt601_converter_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for rgb_to_nv12_bt601_converter_top: directed color blocks, then random pixels
// over random frame sizes and idle patterns; each beat checked against a table or predictor.
// Depends on rgbnv_pkg and the converter RTL.
module rgb_to_nv12_bt601_converter_top_tb;
  import rgbnv_pkg::*;

  localparam int unsigned MAX_W          = 2048;
  localparam int unsigned MAX_H          = 2048;
  localparam int unsigned LINE_DEPTH     = MAX_W / 2;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_PIXELS   = 50;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_WIDTH,
    STEP_HEIGHT
  } step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    logic [23:0] data;
    logic        typed;
    result_t     want;
  } plan_step_t;

  localparam int PLAN_LEN = 24;

  // typed rows: luma, luma_offset, chroma_valid, Cb, Cr, chroma_offset, frame_end
  plan_step_t plan_tbl [PLAN_LEN] = '{
    '{STEP_PIXEL,  24'hFFFFFF, 1'b1, '{235, 0, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'h000000, 1'b1, '{16, 1, 0, 0, 0, 0, 0}},
    '{STEP_WIDTH,  24'h000000, 1'b0, '0},
    '{STEP_HEIGHT, 24'h000001, 1'b0, '0},
    '{STEP_PIXEL,  24'hFFFFFF, 1'b1, '{235, 0, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'hFFFFFF, 1'b1, '{235, 1, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'hFFFFFF, 1'b1, '{235, 2, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'hFFFFFF, 1'b1, '{235, 3, 1, 128, 128, 4, 1}},
    '{STEP_PIXEL,  24'h0000FF, 1'b1, '{41, 0, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'h0000FF, 1'b1, '{41, 1, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'h0000FF, 1'b1, '{41, 2, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'h0000FF, 1'b1, '{41, 3, 1, 240, 110, 4, 1}},
    '{STEP_PIXEL,  24'hFF0000, 1'b1, '{82, 0, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'hFF0000, 1'b1, '{82, 1, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'hFF0000, 1'b1, '{82, 2, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'hFF0000, 1'b1, '{82, 3, 1, 90, 240, 4, 1}},
    '{STEP_PIXEL,  24'h000000, 1'b1, '{16, 0, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'h000000, 1'b1, '{16, 1, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'h000000, 1'b1, '{16, 2, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'h000000, 1'b1, '{16, 3, 1, 128, 128, 4, 1}},
    '{STEP_WIDTH,  24'h000FFF, 1'b0, '0},
    '{STEP_HEIGHT, 24'h000003, 1'b0, '0},
    '{STEP_PIXEL,  24'h00FF00, 1'b1, '{144, 0, 0, 0, 0, 0, 0}},
    '{STEP_PIXEL,  24'h12C84D, 1'b0, '0}
  };

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [7:0]          red_i          = '0;
  logic [7:0]          green_i        = '0;
  logic [7:0]          blue_i         = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [7:0]          luma_o;
  logic [LOFF_W-1:0]   luma_offset_o;
  logic                chroma_valid_o;
  logic [7:0]          blue_diff_o;
  logic [7:0]          red_diff_o;
  logic [COFF_W-1:0]   chroma_offset_o;
  logic                frame_end_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  cfg_reg_e            cfg_index_i    = CFG_FRAME_WIDTH;
  logic [SIZE_W-1:0]   cfg_data_i     = '0;

  logic                beat_typed     = 1'b0;
  result_t             beat_want      = '0;

  int unsigned         idle_pct       = 0;
  int unsigned         stall_pct      = 0;
  int unsigned         quiet_cycles   = 0;
  int unsigned         mismatch_count = 0;
  result_t             predicted_nv12_q [$];

  // predictor state
  logic [SIZE_W-1:0]   width_reg      = 12'd640;
  logic [SIZE_W-1:0]   height_reg     = 12'd480;
  int unsigned         col_pos        = 0;
  int unsigned         row_pos        = 0;
  logic [23:0]         left_hold      = '0;
  logic [26:0]         pair_line [LINE_DEPTH];
  bit                  line_written [LINE_DEPTH];

  rgb_to_nv12_bt601_converter_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic int unsigned frame_dim(logic [SIZE_W-1:0] v, int unsigned max_dim);
    int unsigned d;
    d = {v[SIZE_W-1:1], 1'b0};
    if (d < 2) d = 2;
    if (d > (max_dim & ~32'd1)) d = max_dim & ~32'd1;
    return d;
  endfunction

  function automatic logic [7:0] clip8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  task automatic convert_pixel(input logic [7:0] r, g, b, output result_t res);
    int unsigned w, h, col, row, idx;
    int ri, gi, bi, sr, sg, sb, ar, ag, ab, yv, cbv, crv;
    logic [26:0] entry;
    w = frame_dim(width_reg, MAX_W);
    h = frame_dim(height_reg, MAX_H);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    idx = (col >> 1) % LINE_DEPTH;
    ri = r;
    gi = g;
    bi = b;
    res = '0;
    yv = ((66 * ri + 129 * gi + 25 * bi + 128) >> 8) + 16;
    res.luma = clip8(yv);
    res.luma_offset = LOFF_W'(row * w + col);
    if (!col[0]) begin
      left_hold = {r, g, b};
    end else begin
      sr = left_hold[23:16] + ri;
      sg = left_hold[15:8] + gi;
      sb = left_hold[7:0] + bi;
      if (!row[0]) begin
        pair_line[idx] = {9'(sr), 9'(sg), 9'(sb)};
        line_written[idx] = 1'b1;
      end else begin
        entry = pair_line[idx];
        sr += entry[26:18];
        sg += entry[17:9];
        sb += entry[8:0];
        ar = (sr + 2) >> 2;
        ag = (sg + 2) >> 2;
        ab = (sb + 2) >> 2;
        cbv = ((-38 * ar - 74 * ag + 112 * ab + 128) >>> 8) + 128;
        crv = ((112 * ar - 94 * ag - 18 * ab + 128) >>> 8) + 128;
        res.chroma_valid = 1'b1;
        res.blue_diff = clip8(cbv);
        res.red_diff = clip8(crv);
        res.chroma_offset = COFF_W'(w * h + (row >> 1) * w + col - 1);
      end
    end
    res.frame_end = (col + 1 == w) && (row + 1 == h);
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  // a resize must not make an odd row read pair sums never stored
  function automatic bit line_ready_for(logic [SIZE_W-1:0] w_new, logic [SIZE_W-1:0] h_new);
    int unsigned w, c, r;
    w = frame_dim(w_new, MAX_W);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= frame_dim(h_new, MAX_H)) ? 0 : row_pos;
    if (!r[0]) return 1'b1;
    for (int unsigned i = c >> 1; i < w / 2; i++) begin
      if (!line_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : nv12_check
    result_t want, got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_FRAME_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        convert_pixel(red_i, green_i, blue_i, want);
        if (beat_typed) want = beat_want;
        predicted_nv12_q = {predicted_nv12_q, want};
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{luma_o, luma_offset_o, chroma_valid_o, blue_diff_o, red_diff_o,
                chroma_offset_o, frame_end_o};
        if (predicted_nv12_q.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) $display("unexpected beat: %p", got);
          mismatch_count++;
        end else begin
          want = predicted_nv12_q.pop_front();
          if (got !== want) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("mismatch: expected %p, got %p", want, got);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] r, g, b, input logic typed, input result_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [7:0] random_channel();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_random_pixel();
    send_pixel(random_channel(), random_channel(), random_channel(), 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (predicted_nv12_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [SIZE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic resize_frame(input bit set_w, input logic [SIZE_W-1:0] w_val,
                              input bit set_h, input logic [SIZE_W-1:0] h_val);
    logic [SIZE_W-1:0] w_next, h_next;
    int unsigned w_now, pad;
    wait_drained();
    w_next = set_w ? w_val : width_reg;
    h_next = set_h ? h_val : height_reg;
    // finish the current row at the old size until the new size is safe
    while (!line_ready_for(w_next, h_next)) begin
      w_now = frame_dim(width_reg, MAX_W);
      pad = w_now - ((col_pos >= w_now) ? 0 : col_pos);
      repeat (pad) send_random_pixel();
      wait_drained();
    end
    if (set_w) write_reg(CFG_FRAME_WIDTH, w_val);
    if (set_h) write_reg(CFG_FRAME_HEIGHT, h_val);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return SIZE_W'($urandom_range(2, 24));
    if (roll < 78) return SIZE_W'($urandom_range(0, 3));
    if (roll < 88) return SIZE_W'($urandom);
    case ($urandom_range(0, 3))
      0: return 12'd2048;
      1: return 12'd2049;
      2: return 12'd4095;
      default: return 12'd16;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned roll;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      case (plan_tbl[i].kind)
        STEP_PIXEL: begin
          send_pixel(plan_tbl[i].data[23:16], plan_tbl[i].data[15:8], plan_tbl[i].data[7:0],
                     plan_tbl[i].typed, plan_tbl[i].want);
        end
        STEP_WIDTH: resize_frame(1'b1, plan_tbl[i].data[SIZE_W-1:0], 1'b0, '0);
        default:    resize_frame(1'b0, '0, 1'b1, plan_tbl[i].data[SIZE_W-1:0]);
      endcase
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      roll = $urandom_range(0, 2);
      resize_frame(roll != 1, pick_size(), roll != 0, pick_size());
      repeat (PHASE_PIXELS) send_random_pixel();
    end

    wait_drained();
    if (mismatch_count == 0 && predicted_nv12_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
